// ----- hw/rtl/button_press_auto_repeat_core_macros.svh -----
// ---------------------------------------------------------------------------
// Button press auto-repeat core: assertion macros
// Shared property shapes for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef BUTTON_PRESS_AUTO_REPEAT_CORE_MACROS_SVH
`define BUTTON_PRESS_AUTO_REPEAT_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BPAR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BPAR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/bpar_pkg.sv -----
// ---------------------------------------------------------------------------
// Button press auto-repeat package
// Configuration register map and register file type.
// ---------------------------------------------------------------------------
package bpar_pkg;

    localparam int DATA_W      = 32;
    localparam int TIMER_W     = 16;
    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_REPEATABLE_MASK = 3'd0,
        CFG_PAD_UP_MASK     = 3'd1,
        CFG_PAD_DOWN_MASK   = 3'd2,
        CFG_PAD_LEFT_MASK   = 3'd3,
        CFG_PAD_RIGHT_MASK  = 3'd4,
        CFG_COARSE_MASK     = 3'd5,
        CFG_REPEAT_DELAY    = 3'd6,
        CFG_REPEAT_PERIOD   = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic [DATA_W-1:0]  repeatable_mask;
        logic [DATA_W-1:0]  pad_up_mask;
        logic [DATA_W-1:0]  pad_down_mask;
        logic [DATA_W-1:0]  pad_left_mask;
        logic [DATA_W-1:0]  pad_right_mask;
        logic [DATA_W-1:0]  coarse_mask;
        logic [TIMER_W-1:0] repeat_delay;
        logic [TIMER_W-1:0] repeat_period;
    } t_cfg;

    localparam logic [TIMER_W-1:0] REPEAT_DELAY_RST  = 16'd20;
    localparam logic [TIMER_W-1:0] REPEAT_PERIOD_RST = 16'd5;

endpackage

// ----- hw/rtl/bpar_step.sv -----
// ---------------------------------------------------------------------------
// Button press auto-repeat: per-transaction step logic
// Next state and press word for one accepted transaction.
// ---------------------------------------------------------------------------
module bpar_step #(
    parameter int STICK_UP_BIT    = 28,
    parameter int STICK_DOWN_BIT  = 29,
    parameter int STICK_LEFT_BIT  = 30,
    parameter int STICK_RIGHT_BIT = 31,
    parameter int COUNT_WIDTH     = 16
) (
    input  bpar_pkg::t_cfg                     i_cfg,
    input  logic                               i_mode,
    input  logic [bpar_pkg::DATA_W-1:0]        i_edge_bits,
    input  logic [bpar_pkg::DATA_W-1:0]        i_held_bits,
    input  logic [bpar_pkg::DATA_W-1:0]        i_prior_nav,
    input  logic [COUNT_WIDTH-1:0]             i_hold_count,
    input  logic [COUNT_WIDTH-1:0]             i_repeat_phase,
    input  logic [bpar_pkg::DATA_W-1:0]        i_blocked_bits,
    input  logic [bpar_pkg::DATA_W-1:0]        i_prior_held,
    output logic [bpar_pkg::DATA_W-1:0]        o_prior_nav,
    output logic [COUNT_WIDTH-1:0]             o_hold_count,
    output logic [COUNT_WIDTH-1:0]             o_repeat_phase,
    output logic [bpar_pkg::DATA_W-1:0]        o_blocked_bits,
    output logic [bpar_pkg::DATA_W-1:0]        o_prior_held,
    output logic [bpar_pkg::DATA_W-1:0]        o_press_bits
);

    localparam int CMP_W = (COUNT_WIDTH > bpar_pkg::TIMER_W) ? COUNT_WIDTH
                                                              : bpar_pkg::TIMER_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [bpar_pkg::DATA_W-1:0] STICK_ALL =
        (32'd1 << STICK_UP_BIT) | (32'd1 << STICK_DOWN_BIT) |
        (32'd1 << STICK_LEFT_BIT) | (32'd1 << STICK_RIGHT_BIT);

    logic [bpar_pkg::DATA_W-1:0] nav;
    logic [bpar_pkg::DATA_W-1:0] press;
    logic [bpar_pkg::DATA_W-1:0] blocked_new;
    logic [bpar_pkg::DATA_W-1:0] unblocked;
    logic [bpar_pkg::DATA_W-1:0] pad_all;
    logic [bpar_pkg::DATA_W-1:0] f_coarse;
    logic [bpar_pkg::DATA_W-1:0] f_up;
    logic [bpar_pkg::DATA_W-1:0] f_down;
    logic [bpar_pkg::DATA_W-1:0] f_left;
    logic [bpar_pkg::DATA_W-1:0] f_right;
    logic [COUNT_WIDTH-1:0]      hold_inc;
    logic [COUNT_WIDTH-1:0]      phase_inc;
    logic [COUNT_WIDTH-1:0]      hold_nxt;
    logic [COUNT_WIDTH-1:0]      phase_nxt;
    logic [CMP_W-1:0]            delay_ext;
    logic [CMP_W-1:0]            period_ext;
    logic                        sustained;
    logic                        fire;

    assign nav        = i_held_bits & i_cfg.repeatable_mask;
    assign sustained  = (nav != '0) && (nav == i_prior_nav);
    assign delay_ext  = CMP_W'(i_cfg.repeat_delay);
    assign period_ext = CMP_W'(i_cfg.repeat_period);
    assign hold_inc   = (i_hold_count == CNT_MAX) ? i_hold_count
                                                  : i_hold_count + 1'b1;
    assign phase_inc  = (i_repeat_phase == CNT_MAX) ? i_repeat_phase
                                                    : i_repeat_phase + 1'b1;

    // Delay phase first, then the periodic phase once the delay is reached.
    always_comb begin
        hold_nxt  = '0;
        phase_nxt = '0;
        fire      = 1'b0;
        if (sustained) begin
            if (CMP_W'(i_hold_count) < delay_ext) begin
                hold_nxt = hold_inc;
                fire     = (CMP_W'(hold_inc) == delay_ext);
            end else begin
                hold_nxt = i_hold_count;
                if (CMP_W'(phase_inc) >= period_ext) begin
                    fire = 1'b1;
                end else begin
                    phase_nxt = phase_inc;
                end
            end
        end
    end

    assign blocked_new = i_blocked_bits & i_held_bits;
    assign press       = i_edge_bits | (nav & ~i_prior_nav) | (fire ? nav : '0);
    assign unblocked   = press & ~blocked_new;

    // Fold in order: coarse test first, then each stick direction in turn.
    assign pad_all  = i_cfg.pad_up_mask | i_cfg.pad_down_mask |
                      i_cfg.pad_left_mask | i_cfg.pad_right_mask;
    assign f_coarse = unblocked | (((unblocked & pad_all) != '0) ? i_cfg.coarse_mask : '0);
    assign f_up     = f_coarse | (f_coarse[STICK_UP_BIT]   ? i_cfg.pad_up_mask    : '0);
    assign f_down   = f_up     | (f_up[STICK_DOWN_BIT]     ? i_cfg.pad_down_mask  : '0);
    assign f_left   = f_down   | (f_down[STICK_LEFT_BIT]   ? i_cfg.pad_left_mask  : '0);
    assign f_right  = f_left   | (f_left[STICK_RIGHT_BIT]  ? i_cfg.pad_right_mask : '0);

    always_comb begin
        if (i_mode) begin
            // Screen change: latch the carry block, clear counters.
            o_prior_nav    = i_prior_nav;
            o_hold_count   = '0;
            o_repeat_phase = '0;
            o_blocked_bits = i_prior_held;
            o_prior_held   = i_prior_held;
        end else begin
            o_prior_nav    = nav;
            o_hold_count   = hold_nxt;
            o_repeat_phase = phase_nxt;
            o_blocked_bits = blocked_new;
            o_prior_held   = i_held_bits;
        end
    end

    assign o_press_bits = f_right & ~STICK_ALL;

endmodule

// ----- hw/rtl/button_press_auto_repeat_core.sv -----
// A frame transaction's press word is registered in the output register, or in the skid stage when stalled.
// Throughput: one transaction per cycle while the input is not stalled; the step is a single pass of mask logic
// plus two saturating counters, closed by the output register and a skid stage.
// Screen-change transactions update state only and give no result.
// Reset (synchronous, active low) clears tracking state and output valids, masks to zero, delay 20, period 5.
// ---------------------------------------------------------------------------
// Button press auto-repeat core
// Derives menu presses from per-frame edge and held words: auto-repeat of a
// sustained navigation set, suppression of buttons carried across a screen
// change, and folding of stick directions onto D-pad masks.
// ---------------------------------------------------------------------------
module button_press_auto_repeat_core #(
    parameter int STICK_UP_BIT    = 28,
    parameter int STICK_DOWN_BIT  = 29,
    parameter int STICK_LEFT_BIT  = 30,
    parameter int STICK_RIGHT_BIT = 31,
    parameter int COUNT_WIDTH     = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration write port
    input  logic                                 i_cfg_we,
    input  logic [bpar_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [bpar_pkg::DATA_W-1:0]          i_cfg_data,
    // Input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_mode,
    input  logic [bpar_pkg::DATA_W-1:0]          i_edge_bits,
    input  logic [bpar_pkg::DATA_W-1:0]          i_held_bits,
    // Output channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [bpar_pkg::DATA_W-1:0]          o_press_bits
);

    // Configuration registers
    bpar_pkg::t_cfg r_cfg;

    // Tracking state carried from frame to frame
    logic [bpar_pkg::DATA_W-1:0] r_prior_nav;
    logic [COUNT_WIDTH-1:0]      r_hold_count;
    logic [COUNT_WIDTH-1:0]      r_repeat_phase;
    logic [bpar_pkg::DATA_W-1:0] r_blocked_bits;
    logic [bpar_pkg::DATA_W-1:0] r_prior_held;

    logic [bpar_pkg::DATA_W-1:0] n_prior_nav;
    logic [COUNT_WIDTH-1:0]      n_hold_count;
    logic [COUNT_WIDTH-1:0]      n_repeat_phase;
    logic [bpar_pkg::DATA_W-1:0] n_blocked_bits;
    logic [bpar_pkg::DATA_W-1:0] n_prior_held;
    logic [bpar_pkg::DATA_W-1:0] step_press;

    // Output register and skid stage
    logic                        r_out_valid;
    logic [bpar_pkg::DATA_W-1:0] r_out_bits;
    logic                        r_skid_valid;
    logic [bpar_pkg::DATA_W-1:0] r_skid_bits;
    logic                        n_out_valid;
    logic [bpar_pkg::DATA_W-1:0] n_out_bits;
    logic                        n_skid_valid;
    logic [bpar_pkg::DATA_W-1:0] n_skid_bits;

    logic in_fire;
    logic out_take;
    logic result_new;

    // Config writes are for the user to make only while the core is idle; the block itself does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.repeatable_mask <= '0;
            r_cfg.pad_up_mask     <= '0;
            r_cfg.pad_down_mask   <= '0;
            r_cfg.pad_left_mask   <= '0;
            r_cfg.pad_right_mask  <= '0;
            r_cfg.coarse_mask     <= '0;
            r_cfg.repeat_delay    <= bpar_pkg::REPEAT_DELAY_RST;
            r_cfg.repeat_period   <= bpar_pkg::REPEAT_PERIOD_RST;
        end else if (i_cfg_we) begin
            case (bpar_pkg::t_cfg_reg'(i_cfg_index))
                bpar_pkg::CFG_REPEATABLE_MASK: r_cfg.repeatable_mask <= i_cfg_data;
                bpar_pkg::CFG_PAD_UP_MASK:     r_cfg.pad_up_mask     <= i_cfg_data;
                bpar_pkg::CFG_PAD_DOWN_MASK:   r_cfg.pad_down_mask   <= i_cfg_data;
                bpar_pkg::CFG_PAD_LEFT_MASK:   r_cfg.pad_left_mask   <= i_cfg_data;
                bpar_pkg::CFG_PAD_RIGHT_MASK:  r_cfg.pad_right_mask  <= i_cfg_data;
                bpar_pkg::CFG_COARSE_MASK:     r_cfg.coarse_mask     <= i_cfg_data;
                bpar_pkg::CFG_REPEAT_DELAY: begin
                    r_cfg.repeat_delay <= i_cfg_data[bpar_pkg::TIMER_W-1:0];
                end
                bpar_pkg::CFG_REPEAT_PERIOD: begin
                    r_cfg.repeat_period <= i_cfg_data[bpar_pkg::TIMER_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Hold off new transactions only when both result slots are occupied.
    assign o_in_stall = r_skid_valid;
    assign in_fire    = i_in_valid && !r_skid_valid;
    assign out_take   = r_out_valid && !i_out_stall;
    assign result_new = in_fire && !i_mode;

    // Single-pass step: all work for one transaction happens here.
    bpar_step #(
        .STICK_UP_BIT    (STICK_UP_BIT),
        .STICK_DOWN_BIT  (STICK_DOWN_BIT),
        .STICK_LEFT_BIT  (STICK_LEFT_BIT),
        .STICK_RIGHT_BIT (STICK_RIGHT_BIT),
        .COUNT_WIDTH     (COUNT_WIDTH)
    ) u_step (
        .i_cfg          (r_cfg),
        .i_mode         (i_mode),
        .i_edge_bits    (i_edge_bits),
        .i_held_bits    (i_held_bits),
        .i_prior_nav    (r_prior_nav),
        .i_hold_count   (r_hold_count),
        .i_repeat_phase (r_repeat_phase),
        .i_blocked_bits (r_blocked_bits),
        .i_prior_held   (r_prior_held),
        .o_prior_nav    (n_prior_nav),
        .o_hold_count   (n_hold_count),
        .o_repeat_phase (n_repeat_phase),
        .o_blocked_bits (n_blocked_bits),
        .o_prior_held   (n_prior_held),
        .o_press_bits   (step_press)
    );

    // Advance tracking state on every accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prior_nav    <= '0;
            r_hold_count   <= '0;
            r_repeat_phase <= '0;
            r_blocked_bits <= '0;
            r_prior_held   <= '0;
        end else if (in_fire) begin
            r_prior_nav    <= n_prior_nav;
            r_hold_count   <= n_hold_count;
            r_repeat_phase <= n_repeat_phase;
            r_blocked_bits <= n_blocked_bits;
            r_prior_held   <= n_prior_held;
        end
    end

    // Output register plus skid: the skid fills only when a new result
    // arrives while the output register is full and stalled.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_bits   = r_out_bits;
        n_skid_valid = r_skid_valid;
        n_skid_bits  = r_skid_bits;
        if (out_take) begin
            if (r_skid_valid) begin
                // Drain the skid; input is stalled, so no new result here.
                n_out_bits   = r_skid_bits;
                n_skid_valid = 1'b0;
            end else if (result_new) begin
                n_out_bits = step_press;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (result_new) begin
            if (!r_out_valid) begin
                n_out_valid = 1'b1;
                n_out_bits  = step_press;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_bits  = step_press;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_bits  <= n_out_bits;
        r_skid_bits <= n_skid_bits;
    end

    assign o_out_valid  = r_out_valid;
    assign o_press_bits = r_out_bits;

endmodule

// ----- hw/rtl/bpar_checker.sv -----
// ---------------------------------------------------------------------------
// Button press auto-repeat: port checker
// Port-level properties of the core, attached by bind.
// ---------------------------------------------------------------------------
`include "button_press_auto_repeat_core_macros.svh"

module bpar_checker #(
    parameter int STICK_UP_BIT    = 28,
    parameter int STICK_DOWN_BIT  = 29,
    parameter int STICK_LEFT_BIT  = 30,
    parameter int STICK_RIGHT_BIT = 31
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          i_mode,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [bpar_pkg::DATA_W-1:0]   o_press_bits
);

    logic in_fire;
    logic stick_seen;

    assign in_fire    = i_in_valid && !o_in_stall;
    assign stick_seen = o_press_bits[STICK_UP_BIT] || o_press_bits[STICK_DOWN_BIT] ||
                        o_press_bits[STICK_LEFT_BIT] || o_press_bits[STICK_RIGHT_BIT];

    // Hold a stalled result steady.
    `BPAR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_press_bits), "stalled result changed or dropped")

    // A frame transaction always leaves a result waiting the next cycle.
    `BPAR_ASSERT_NEXT(a_frame_result, i_clk, i_rst_n, in_fire && !i_mode,
        o_out_valid, "frame transaction produced no result")

    // A screen change into an empty output gives nothing.
    `BPAR_ASSERT_NEXT(a_screen_silent, i_clk, i_rst_n, in_fire && i_mode && !o_out_valid,
        !o_out_valid, "screen change produced a result")

    // Stick bits are always cleared from the press word.
    `BPAR_ASSERT_NOW(a_no_stick, i_clk, i_rst_n, o_out_valid,
        !stick_seen, "stick bit present in result")

    // Input back-pressure only while a result is pending.
    `BPAR_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_in_stall,
        o_out_valid, "input stalled with empty output")

endmodule

bind button_press_auto_repeat_core bpar_checker #(
    .STICK_UP_BIT    (STICK_UP_BIT),
    .STICK_DOWN_BIT  (STICK_DOWN_BIT),
    .STICK_LEFT_BIT  (STICK_LEFT_BIT),
    .STICK_RIGHT_BIT (STICK_RIGHT_BIT)
) u_bpar_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .i_mode       (i_mode),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_press_bits (o_press_bits)
);
